[hdl/imuac_pkg.sv]
// Package for the IMU affine axis calibration block.
// Holds widths, register codes, reset values and shared types.
// No dependencies; every other file imports it.
package imuac_pkg;

    // Fraction bits of the Q2.14 coefficients
    localparam int COEF_FRAC_BITS = 14;

    localparam int AXES   = 3;
    localparam int RAW_W  = 16;
    localparam int COEF_W = 16;
    localparam int OFS_W  = 16;
    localparam int DIFF_W = RAW_W + 1;
    localparam int PROD_W = COEF_W + DIFF_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int CORR_W = 20;
    localparam int REG_W  = AXES * COEF_W;
    localparam int IDX_W  = 3;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_ACC_ROW0    = 3'd0,
        REG_ACC_ROW1    = 3'd1,
        REG_ACC_ROW2    = 3'd2,
        REG_GYRO_ROW0   = 3'd3,
        REG_GYRO_ROW1   = 3'd4,
        REG_GYRO_ROW2   = 3'd5,
        REG_ACC_OFFSETS = 3'd6,
        REG_GYRO_OFFSETS = 3'd7
    } cfg_idx_t;

    // Unity coefficient and identity rows after reset
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC_BITS);
    localparam logic [REG_W-1:0]  ROW0_RESET = REG_W'(COEF_ONE);
    localparam logic [REG_W-1:0]  ROW1_RESET = REG_W'(COEF_ONE) << COEF_W;
    localparam logic [REG_W-1:0]  ROW2_RESET = REG_W'(COEF_ONE) << (2 * COEF_W);

    typedef logic [AXES-1:0][COEF_W-1:0] coef_vec_t;
    typedef logic [AXES-1:0][PROD_W-1:0] prod_vec_t;

    // Full calibration set as held in the register file
    typedef struct packed {
        logic [AXES-1:0][REG_W-1:0] acc_row;
        logic [AXES-1:0][REG_W-1:0] gyro_row;
        logic [REG_W-1:0]           acc_ofs;
        logic [REG_W-1:0]           gyro_ofs;
    } cfg_set_t;

    // Stage load strobes for the lanes
    typedef struct packed {
        logic load_diff;
        logic load_prod;
    } pipe_ctrl_t;

endpackage

[hdl/imuac_if.sv]
// Channel interfaces: sample input, corrected output, configuration writes.
// Depends on imuac_pkg.
interface imuac_samp_if;
    import imuac_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [RAW_W-1:0]  raw_x;
    logic signed [RAW_W-1:0]  raw_y;
    logic signed [RAW_W-1:0]  raw_z;
    modport source (output valid, mode, raw_x, raw_y, raw_z, input ready);
    modport sink   (input valid, mode, raw_x, raw_y, raw_z, output ready);
endinterface

interface imuac_corr_if;
    import imuac_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     sensor_kind;
    logic signed [CORR_W-1:0] corr_x;
    logic signed [CORR_W-1:0] corr_y;
    logic signed [CORR_W-1:0] corr_z;
    modport source (output valid, sensor_kind, corr_x, corr_y, corr_z, input ready);
    modport sink   (input valid, sensor_kind, corr_x, corr_y, corr_z, output ready);
endinterface

interface imuac_cfg_if;
    import imuac_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [REG_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/imuac_cfg_regs.sv]
// Configuration register file: two 3x3 matrices and two offset vectors.
// Depends on imuac_pkg.
module imuac_cfg_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [imuac_pkg::IDX_W-1:0] wr_index,
    input  logic [imuac_pkg::REG_W-1:0] wr_data,
    output imuac_pkg::cfg_set_t    cfg_set
);
    import imuac_pkg::*;

    cfg_set_t set_reg;

    // Register writes; identity matrices and zero offsets after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg.acc_row[0]  <= ROW0_RESET;
            set_reg.acc_row[1]  <= ROW1_RESET;
            set_reg.acc_row[2]  <= ROW2_RESET;
            set_reg.gyro_row[0] <= ROW0_RESET;
            set_reg.gyro_row[1] <= ROW1_RESET;
            set_reg.gyro_row[2] <= ROW2_RESET;
            set_reg.acc_ofs     <= '0;
            set_reg.gyro_ofs    <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_index))
                REG_ACC_ROW0:     set_reg.acc_row[0]  <= wr_data;
                REG_ACC_ROW1:     set_reg.acc_row[1]  <= wr_data;
                REG_ACC_ROW2:     set_reg.acc_row[2]  <= wr_data;
                REG_GYRO_ROW0:    set_reg.gyro_row[0] <= wr_data;
                REG_GYRO_ROW1:    set_reg.gyro_row[1] <= wr_data;
                REG_GYRO_ROW2:    set_reg.gyro_row[2] <= wr_data;
                REG_ACC_OFFSETS:  set_reg.acc_ofs     <= wr_data;
                REG_GYRO_OFFSETS: set_reg.gyro_ofs    <= wr_data;
                default:          set_reg.acc_ofs     <= set_reg.acc_ofs;
            endcase
        end
    end

    assign cfg_set = set_reg;

endmodule

[hdl/imuac_lane.sv]
// One input-axis lane: offset removal, then products with one matrix column.
// Depends on imuac_pkg.
module imuac_lane (
    input  logic                          clk,
    input  imuac_pkg::pipe_ctrl_t         ctrl,
    input  logic                          mode,
    input  logic signed [imuac_pkg::RAW_W-1:0] raw,
    input  logic [imuac_pkg::OFS_W-1:0]   acc_ofs,
    input  logic [imuac_pkg::OFS_W-1:0]   gyro_ofs,
    input  imuac_pkg::coef_vec_t          acc_col,
    input  imuac_pkg::coef_vec_t          gyro_col,
    output imuac_pkg::prod_vec_t          prod
);
    import imuac_pkg::*;

    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W-1:0] diff_next;
    logic [OFS_W-1:0]         ofs_sel;
    coef_vec_t                coef_reg;
    coef_vec_t                coef_next;
    prod_vec_t                prod_reg;
    prod_vec_t                prod_next;

    // Pick the set for this item and remove the offset (17-bit result)
    always_comb
    begin
        ofs_sel   = mode ? gyro_ofs : acc_ofs;
        coef_next = mode ? gyro_col : acc_col;
        diff_next = DIFF_W'(raw) - DIFF_W'($signed(ofs_sel));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_diff)
        begin
            diff_reg <= diff_next;
            coef_reg <= coef_next;
        end
    end

    // Three 16x17 products, one per output row
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            prod_next[i] = PROD_W'($signed(coef_reg[i])) * PROD_W'(diff_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

[hdl/imuac_merge.sv]
// Merge stage: sums lane products per output row, floor shift, output register.
// Depends on imuac_pkg.
module imuac_merge (
    input  logic                           clk,
    input  logic                           load,
    input  logic                           mode,
    input  imuac_pkg::prod_vec_t           lane_prod [imuac_pkg::AXES],
    output logic                           sensor_kind,
    output logic signed [imuac_pkg::CORR_W-1:0] corr_x,
    output logic signed [imuac_pkg::CORR_W-1:0] corr_y,
    output logic signed [imuac_pkg::CORR_W-1:0] corr_z
);
    import imuac_pkg::*;

    logic signed [SUM_W-1:0]  sum [AXES];
    logic [CORR_W-1:0]        corr_next [AXES];
    logic [CORR_W-1:0]        corr_reg [AXES];
    logic                     kind_reg;

    // Row sum over the three lanes; arithmetic shift is floor rounding
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            sum[i] = SUM_W'($signed(lane_prod[0][i]))
                   + SUM_W'($signed(lane_prod[1][i]))
                   + SUM_W'($signed(lane_prod[2][i]));
            corr_next[i] = sum[i][COEF_FRAC_BITS +: CORR_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            corr_reg <= corr_next;
            kind_reg <= mode;
        end
    end

    assign sensor_kind = kind_reg;
    assign corr_x      = $signed(corr_reg[0]);
    assign corr_y      = $signed(corr_reg[1]);
    assign corr_z      = $signed(corr_reg[2]);

endmodule

[hdl/imu_affine_axis_calibration.sv]
// IMU affine calibration top level: offset removal and 3x3 matrix per sample.
// Pipeline: 3 register stages; an accepted item passes in turn through the lane
// difference register, the lane product register and the merge output register.
// Throughput: one item per cycle while corr.ready holds, through the lane/merge pipeline.
// Stages hold valid bits and fill bubbles, so a stalled output still lets
// earlier stages take items. Reset clears valids; matrices go to identity.
// Depends on imuac_pkg, imuac_if, imuac_cfg_regs, imuac_lane, imuac_merge.
module imu_affine_axis_calibration (
    input  logic            clk,
    input  logic            rst_n,
    imuac_samp_if.sink      samp,
    imuac_corr_if.source    corr,
    imuac_cfg_if.sink       cfg
);
    import imuac_pkg::*;

    cfg_set_t                 cfg_set;
    pipe_ctrl_t               ctrl;
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    logic                     mode1_reg;
    logic                     mode2_reg;
    logic                     en1;
    logic                     en2;
    logic                     en3;
    logic signed [RAW_W-1:0]  raw [AXES];
    coef_vec_t                acc_col [AXES];
    coef_vec_t                gyro_col [AXES];
    prod_vec_t                lane_prod [AXES];

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    imuac_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg_set  (cfg_set)
    );

    // Stage enables: a stage loads when empty or when it passes its item on
    assign en3  = !v3_reg || corr.ready;
    assign en2  = !v2_reg || en3;
    assign en1  = !v1_reg || en2;
    assign samp.ready = en1;

    assign ctrl.load_diff = en1;
    assign ctrl.load_prod = en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= samp.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Mode travels with the item
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mode1_reg <= samp.mode;
        end
        if (en2)
        begin
            mode2_reg <= mode1_reg;
        end
    end

    assign raw[0] = samp.raw_x;
    assign raw[1] = samp.raw_y;
    assign raw[2] = samp.raw_z;

    // Lane j sees column j of each matrix and offset j
    for (genvar j = 0; j < AXES; j++)
    begin : g_lane
        always_comb
        begin
            for (int i = 0; i < AXES; i++)
            begin
                acc_col[j][i]  = cfg_set.acc_row[i][COEF_W*j +: COEF_W];
                gyro_col[j][i] = cfg_set.gyro_row[i][COEF_W*j +: COEF_W];
            end
        end

        imuac_lane u_lane (
            .clk      (clk),
            .ctrl     (ctrl),
            .mode     (samp.mode),
            .raw      (raw[j]),
            .acc_ofs  (cfg_set.acc_ofs[OFS_W*j +: OFS_W]),
            .gyro_ofs (cfg_set.gyro_ofs[OFS_W*j +: OFS_W]),
            .acc_col  (acc_col[j]),
            .gyro_col (gyro_col[j]),
            .prod     (lane_prod[j])
        );
    end

    imuac_merge u_merge (
        .clk         (clk),
        .load        (en3),
        .mode        (mode2_reg),
        .lane_prod   (lane_prod),
        .sensor_kind (corr.sensor_kind),
        .corr_x      (corr.corr_x),
        .corr_y      (corr.corr_y),
        .corr_z      (corr.corr_z)
    );

    assign corr.valid = v3_reg;

endmodule
